// ===== hdl/mwem_pkg.sv =====
// mwem_pkg: shared sizes, field structs, command and state codes for the
// minimum-weight edge merge block. No dependencies.
`default_nettype none
package mwem_pkg;

	localparam int MAX_VERTICES = 4096;
	localparam int IDX_W        = $clog2(MAX_VERTICES);
	localparam int RANK_W       = $clog2(MAX_VERTICES + 1);
	localparam int WEIGHT_W     = 31;
	localparam int MODE_W       = 2;

	// Valid bits live in rows of ROW_LEN entries; one summary flop per row.
	localparam int COL_W   = (IDX_W < 5) ? IDX_W : 5;
	localparam int ROW_LEN = 1 << COL_W;
	localparam int ROWS    = (MAX_VERTICES + ROW_LEN - 1) / ROW_LEN;
	localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int SCAN_N  = 8;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [MODE_W-1:0] MODE_LOAD  = MODE_W'(0);
	localparam logic [MODE_W-1:0] MODE_EDGE  = MODE_W'(1);
	localparam logic [MODE_W-1:0] MODE_DRAIN = MODE_W'(2);

	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [IDX_W-1:0]    label;
		logic [RANK_W-1:0]   rank;
		logic [WEIGHT_W-1:0] weight;
		logic [IDX_W-1:0]    self_label;
	} mwem_in_t;

	typedef struct packed {
		logic                entry_valid;
		logic [IDX_W-1:0]    new_vertex;
		logic [WEIGHT_W-1:0] min_weight;
		logic                group_end;
	} mwem_out_t;

	typedef enum logic [1:0] {
		CMD_LOAD,
		CMD_EDGE,
		CMD_DRAIN
	} mwem_cmd_t;

	typedef struct packed {
		mwem_cmd_t           cmd;
		logic [IDX_W-1:0]    label;
		logic [RANK_W-1:0]   rank;
		logic [WEIGHT_W-1:0] weight;
	} mwem_op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} mwem_q_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_E_RANK,
		ST_E_RMW,
		ST_SCAN,
		ST_ROWCHK,
		ST_WOUT,
		ST_END
	} mwem_state_t;

endpackage
`default_nettype wire

// ===== hdl/mwem_front.sv =====
// mwem_front: accepts input beats, drops self-loops, out-of-range labels and
// unused modes, and pushes the rest as commands. Depends on mwem_pkg.
`default_nettype none
module mwem_front import mwem_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         item_valid,
	output logic              item_ready,
	input  wire mwem_in_t     item,
	input  wire mwem_q_stat_t q_stat,
	output logic              push,
	output mwem_op_t          push_op
);

	logic keep;
	logic label_ok;
	logic seen_q;

	// label width covers the table exactly only for power-of-two depths
	assign label_ok = ({1'b0, item.label} < (IDX_W + 1)'(MAX_VERTICES));

	always_comb begin
		keep           = 1'b0;
		push_op.cmd    = CMD_LOAD;
		push_op.label  = item.label;
		push_op.rank   = item.rank;
		push_op.weight = item.weight;
		unique case (item.mode)
			MODE_LOAD: begin
				keep        = label_ok;
				push_op.cmd = CMD_LOAD;
			end
			MODE_EDGE: begin
				keep        = label_ok && (item.label != item.self_label);
				push_op.cmd = CMD_EDGE;
			end
			MODE_DRAIN: begin
				keep        = 1'b1;
				push_op.cmd = CMD_DRAIN;
			end
			default: keep = 1'b0;
		endcase
	end

	// hold ready low out of reset until seen_q is set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else begin
			seen_q <= 1'b1;
		end
	end

	assign item_ready = seen_q && !q_stat.full;
	assign push       = item_valid && item_ready && keep;

endmodule
`default_nettype wire

// ===== hdl/mwem_fifo.sv =====
// mwem_fifo: short command queue between front and back.
// Depends on mwem_pkg.
`default_nettype none
module mwem_fifo import mwem_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire mwem_op_t push_op,
	input  wire logic     pop,
	output mwem_op_t      head,
	output mwem_q_stat_t  stat
);

	mwem_op_t           slot_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wptr_q;
	logic [FIFO_AW-1:0] rptr_q;
	logic [FIFO_AW:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign stat.full  = (count_q == (FIFO_AW + 1)'(FIFO_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hdl/mwem_back.sv =====
// mwem_back: executes commands against the rank, weight and valid-row
// memories and drives the result register. Depends on mwem_pkg.
`default_nettype none
module mwem_back import mwem_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire mwem_op_t     head,
	input  wire mwem_q_stat_t q_stat,
	output logic              pop,
	output logic              result_valid,
	input  wire logic         result_ready,
	output mwem_out_t         result
);

	localparam int CW = ROW_AW + 4;

	mwem_state_t state_q, state_nx;

	// memories
	logic [RANK_W-1:0]   rank_mem [MAX_VERTICES];
	logic [WEIGHT_W-1:0] w_mem    [MAX_VERTICES];
	logic [ROW_LEN-1:0]  vrow_mem [ROWS];
	logic [RANK_W-1:0]   rank_rd_q;
	logic [WEIGHT_W-1:0] w_rd_q;
	logic [ROW_LEN-1:0]  vrow_rd_q;

	logic                rank_we, rank_re, w_we, w_re, vrow_we, vrow_re;
	logic [IDX_W-1:0]    w_addr;
	logic [ROW_AW-1:0]   vrow_addr;
	logic [WEIGHT_W-1:0] w_wd;
	logic [ROW_LEN-1:0]  vrow_wd;

	logic [ROWS-1:0]     summ_q;
	logic                summ_we, summ_wd;
	logic [ROW_AW-1:0]   summ_wa;

	// working registers
	logic [IDX_W-1:0]    ptr_q;
	logic [ROW_AW-1:0]   row_q, hit_q;
	logic                first_q, hit_first_q;
	logic [IDX_W-1:0]    slot_q, idx_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic                out_valid_q;
	mwem_out_t           out_q;

	// combinational datapath
	logic                out_free;
	logic                scan_found, scan_last;
	logic [ROW_AW-1:0]   scan_hit;
	logic                scan_at0;
	logic [CW-1:0]       cand;
	logic [CW-1:0]       row_step;
	logic [ROW_LEN-1:0]  col_mask, masked;
	logic                row_any;
	logic [COL_W-1:0]    col_sel;
	logic [IDX_W-1:0]    idx_hit;
	logic [ROW_AW:0]     hit_next;
	logic                hit_next_end;
	logic [IDX_W:0]      idx_inc;
	logic                rank_ok;
	logic [IDX_W-1:0]    slot_nx;
	logic [ROW_AW-1:0]   slot_row;
	logic [COL_W-1:0]    slot_col;
	logic [ROW_LEN-1:0]  edge_row, edge_bit;
	logic                emit_entry, emit_end;

	assign out_free = !out_valid_q || result_ready;

	// group scan over the row summary flops
	always_comb begin
		scan_found = 1'b0;
		scan_hit   = row_q;
		scan_at0   = 1'b0;
		cand       = '0;
		for (int i = 0; i < SCAN_N; i++) begin
			cand = CW'(row_q) + CW'(i);
			if (!scan_found && (cand < CW'(ROWS)) && summ_q[cand[ROW_AW-1:0]]) begin
				scan_found = 1'b1;
				scan_hit   = cand[ROW_AW-1:0];
				scan_at0   = (i == 0);
			end
		end
		row_step  = CW'(row_q) + CW'(SCAN_N);
		scan_last = (row_step >= CW'(ROWS));
	end

	// first set bit at or above the start column
	assign col_mask = hit_first_q ? ({ROW_LEN{1'b1}} << ptr_q[COL_W-1:0]) : {ROW_LEN{1'b1}};
	assign masked   = vrow_rd_q & col_mask;
	assign row_any  = |masked;

	always_comb begin
		col_sel = '0;
		for (int i = ROW_LEN - 1; i >= 0; i--) begin
			if (masked[i]) begin
				col_sel = COL_W'(i);
			end
		end
	end

	assign idx_hit      = IDX_W'({hit_q, col_sel});
	assign idx_inc      = {1'b0, idx_hit} + 1'b1;
	assign hit_next     = {1'b0, hit_q} + 1'b1;
	assign hit_next_end = (hit_next >= (ROW_AW + 1)'(ROWS));

	// edge slot from the rank read
	assign rank_ok  = (rank_rd_q != '0) && (rank_rd_q <= RANK_W'(MAX_VERTICES));
	assign slot_nx  = IDX_W'(rank_rd_q - 1'b1);
	assign slot_row = ROW_AW'(slot_q >> COL_W);
	assign slot_col = slot_q[COL_W-1:0];
	assign edge_row = summ_q[slot_row] ? vrow_rd_q : '0;
	assign edge_bit = ROW_LEN'(1) << slot_col;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_stat.empty) begin
					unique case (head.cmd)
						CMD_EDGE:  state_nx = ST_E_RANK;
						CMD_DRAIN: state_nx = ST_SCAN;
						default:   state_nx = ST_IDLE;
					endcase
				end
			end
			ST_E_RANK: state_nx = rank_ok ? ST_E_RMW : ST_IDLE;
			ST_E_RMW:  state_nx = ST_IDLE;
			ST_SCAN: begin
				if (scan_found) begin
					state_nx = ST_ROWCHK;
				end else if (scan_last) begin
					state_nx = ST_END;
				end
			end
			ST_ROWCHK: begin
				if (row_any) begin
					state_nx = ST_WOUT;
				end else if (hit_next_end) begin
					state_nx = ST_END;
				end else begin
					state_nx = ST_SCAN;
				end
			end
			ST_WOUT: state_nx = out_free ? ST_IDLE : ST_WOUT;
			ST_END:  state_nx = out_free ? ST_IDLE : ST_END;
			default: state_nx = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		pop        = 1'b0;
		rank_we    = 1'b0;
		rank_re    = 1'b0;
		w_we       = 1'b0;
		w_re       = 1'b0;
		w_addr     = slot_q;
		w_wd       = weight_q;
		vrow_we    = 1'b0;
		vrow_re    = 1'b0;
		vrow_addr  = slot_row;
		vrow_wd    = edge_row | edge_bit;
		summ_we    = 1'b0;
		summ_wa    = slot_row;
		summ_wd    = 1'b1;
		emit_entry = 1'b0;
		emit_end   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				pop     = !q_stat.empty;
				rank_we = !q_stat.empty && (head.cmd == CMD_LOAD);
				rank_re = !q_stat.empty && (head.cmd == CMD_EDGE);
			end
			ST_E_RANK: begin
				w_re      = rank_ok;
				w_addr    = slot_nx;
				vrow_re   = rank_ok;
				vrow_addr = ROW_AW'(slot_nx >> COL_W);
			end
			ST_E_RMW: begin
				if (!edge_row[slot_col]) begin
					w_we    = 1'b1;
					vrow_we = 1'b1;
					summ_we = 1'b1;
				end else if (weight_q < w_rd_q) begin
					w_we = 1'b1;
				end
			end
			ST_SCAN: begin
				vrow_re   = scan_found;
				vrow_addr = scan_hit;
			end
			ST_ROWCHK: begin
				w_re      = row_any;
				w_addr    = idx_hit;
				vrow_we   = row_any;
				vrow_addr = hit_q;
				vrow_wd   = vrow_rd_q & ~(ROW_LEN'(1) << col_sel);
				summ_we   = row_any;
				summ_wa   = hit_q;
				summ_wd   = |(vrow_rd_q & ~(ROW_LEN'(1) << col_sel));
			end
			ST_WOUT: emit_entry = out_free;
			ST_END:  emit_end   = out_free;
			default: ;
		endcase
	end

	// memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (rank_we) begin
			rank_mem[head.label] <= head.rank;
		end
		if (rank_re) begin
			rank_rd_q <= rank_mem[head.label];
		end
	end

	always_ff @(posedge clk) begin
		if (w_we) begin
			w_mem[w_addr] <= w_wd;
		end
		if (w_re) begin
			w_rd_q <= w_mem[w_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (vrow_we) begin
			vrow_mem[vrow_addr] <= vrow_wd;
		end
		if (vrow_re) begin
			vrow_rd_q <= vrow_mem[vrow_addr];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && !q_stat.empty) begin
			weight_q <= head.weight;
		end
		if (state_q == ST_E_RANK) begin
			slot_q <= slot_nx;
		end
		if (state_q == ST_SCAN && scan_found) begin
			hit_q       <= scan_hit;
			hit_first_q <= first_q && scan_at0;
		end
		if (state_q == ST_ROWCHK) begin
			idx_q <= idx_hit;
		end
		if (emit_entry) begin
			out_q.entry_valid <= 1'b1;
			out_q.new_vertex  <= idx_q;
			out_q.min_weight  <= w_rd_q;
			out_q.group_end   <= 1'b0;
		end else if (emit_end) begin
			out_q.entry_valid <= 1'b0;
			out_q.new_vertex  <= '0;
			out_q.min_weight  <= '0;
			out_q.group_end   <= 1'b1;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			summ_q      <= '0;
			ptr_q       <= '0;
			row_q       <= '0;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (summ_we) begin
				summ_q[summ_wa] <= summ_wd;
			end
			if (state_q == ST_IDLE && !q_stat.empty && head.cmd == CMD_DRAIN) begin
				row_q   <= ROW_AW'(ptr_q >> COL_W);
				first_q <= 1'b1;
			end
			if (state_q == ST_SCAN && !scan_found && !scan_last) begin
				row_q   <= row_step[ROW_AW-1:0];
				first_q <= 1'b0;
			end
			if (state_q == ST_ROWCHK && !row_any && !hit_next_end) begin
				row_q   <= hit_next[ROW_AW-1:0];
				first_q <= 1'b0;
			end
			if (state_q == ST_ROWCHK && row_any) begin
				ptr_q <= (idx_inc == (IDX_W + 1)'(MAX_VERTICES)) ? '0 : idx_inc[IDX_W-1:0];
			end
			if (emit_end) begin
				ptr_q <= '0;
			end
			if (emit_entry || emit_end) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule
`default_nettype wire

// ===== hdl/min_weight_edge_merge_top.sv =====
// min_weight_edge_merge_top: top level of the minimum-weight edge merge.
// Depends on mwem_pkg, mwem_front, mwem_fifo and mwem_back.
`default_nettype none
// Merges the edges of one contracted supervertex. Load beats (mode 0) write
// the label-to-rank table; edge beats (mode 1) look up the neighbour's rank
// and keep the lightest weight at slot rank-1; drain beats (mode 2) return
// the next occupied slot in ascending order and clear it, or an end marker
// once nothing remains at or above the drain pointer. Self-loops, labels
// past the table and mode 3 are dropped at the front and give no result.
// Only drain beats produce a result beat. One command runs at a time in
// the back end. A load writes the rank table as it is popped; an edge
// reads the rank, then reads the weight and valid row at slot rank-1,
// then writes back. A drain scans from the pointer's row upward over the
// 32-entry valid rows; a pointer row that holds nothing at or above the
// pointer is read for nothing before the scan moves on. The summary scan
// looks at 8 row flags per cycle and a hit row is read from the valid-row
// memory. A drain also waits while an earlier result beat is held.
// A two-entry command queue lets input beats keep arriving while the back
// end works or a result waits for result_ready. No clearing pass: reset
// clears the per-row summary flags, and a row whose flag is low reads as
// empty. Rank entries must be loaded before edges reference them.
module min_weight_edge_merge_top import mwem_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     item_valid,
	output logic          item_ready,
	input  wire mwem_in_t item,
	output logic          result_valid,
	input  wire logic     result_ready,
	output mwem_out_t     result
);

	mwem_q_stat_t q_stat;
	mwem_op_t     push_op;
	mwem_op_t     head;
	logic         push;
	logic         pop;

	// front: accept and classify
	mwem_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_stat     (q_stat),
		.push       (push),
		.push_op    (push_op)
	);

	// command queue decouples the two sides
	mwem_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head    (head),
		.stat    (q_stat)
	);

	// back: tables, drain scan, result register
	mwem_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_stat       (q_stat),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
`default_nettype wire
